// ===== src/tbp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbp_pkg
// shared types, constants and helper functions of the tage branch predictor
// ----------------------------------------------------------------------------
package tbp_pkg;

	localparam int MAX_TABLES          = 12;
	localparam int NUM_TABLES_DEF      = 12;
	localparam int BIMODAL_ENTRIES_DEF = 16384;
	localparam int MAX_HISTORY_DEF     = 640;
	localparam int PATH_BITS_DEF       = 16;

	localparam int MAX_IDX_W  = 11;
	localparam int TAG_W      = 15;
	localparam int CTR_W      = 3;
	localparam int TBL_ID_W   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int IDX_WIDTH [MAX_TABLES] = '{9, 9, 10, 10, 10, 10, 11, 11, 11, 11, 10, 10};
	localparam int TAG_WIDTH [MAX_TABLES] = '{15, 14, 13, 12, 12, 11, 10, 9, 8, 8, 7, 7};
	localparam int HIST_LEN  [MAX_TABLES] = '{640, 430, 254, 160, 101, 64, 40, 25, 16, 10, 6, 4};

	localparam logic [15:0] LFSR_MASK    = 16'hB400;
	localparam logic [1:0]  BIM_RESET    = 2'd2;
	localparam logic [7:0]  AGING_RESET  = 8'd20;
	localparam logic [4:0]  ALLOC_RESET  = 5'd12;
	localparam logic [15:0] LFSR_RESET   = 16'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AGING_PERIOD = 2'd0,
		CFG_ALLOC_ONE_IN = 2'd1,
		CFG_LFSR_SEED    = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_ALLOC_HI,
		ST_ALLOC_LO,
		ST_AGE
	} tbp_state_t;

	typedef struct packed {
		logic [63:0] pc;
		logic        taken;
	} tbp_req_t;

	typedef struct packed {
		logic                predicted_taken;
		logic [TBL_ID_W-1:0] provider_table;
		logic                used_alternate;
		logic [TBL_ID_W-1:0] allocated_table;
	} tbp_rsp_t;

	typedef struct packed {
		logic                 we_tc;
		logic                 we_u0;
		logic                 we_u1;
		logic [MAX_IDX_W-1:0] addr;
		logic [TAG_W-1:0]     tag;
		logic [CTR_W-1:0]     ctr;
		logic [1:0]           u;
	} tbp_bank_wr_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [CTR_W-1:0] ctr;
		logic [1:0]       u;
	} tbp_bank_rd_t;

	typedef struct packed {
		logic shift;
		logic taken;
	} tbp_hist_ctl_t;

	function automatic logic [CTR_W-1:0] sat_ctr(input logic [CTR_W-1:0] v, input logic up);
		if (up && v != 3'd7)
			return v + 3'd1;
		if (!up && v != 3'd0)
			return v - 3'd1;
		return v;
	endfunction

	function automatic logic [1:0] sat_2b(input logic [1:0] v, input logic up);
		if (up && v != 2'd3)
			return v + 2'd1;
		if (!up && v != 2'd0)
			return v - 2'd1;
		return v;
	endfunction

	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		logic [15:0] s;
		s = v >> 1;
		if (v[0])
			s = s ^ LFSR_MASK;
		return s;
	endfunction

	// one byte of a restoring remainder, msb first
	function automatic logic [4:0] mod_byte(input logic [4:0] rem, input logic [7:0] b,
			input logic [4:0] div);
		logic [5:0] r;
		logic [5:0] d;
		d = (div == 5'd0) ? 6'd1 : {1'b0, div};
		r = {1'b0, rem};
		for (int k = 7; k >= 0; k--) begin
			r = {r[4:0], b[k]};
			if (r >= d)
				r = r - d;
		end
		return r[4:0];
	endfunction

endpackage

// ===== src/tbp_bank.sv =====
// ----------------------------------------------------------------------------
// tbp_bank
// one tagged table: tag and counter memory plus two useful bit columns
// ----------------------------------------------------------------------------
module tbp_bank #(
	parameter int IDX_W = 9
) (
	input  logic                            clk,
	input  logic                            rd_en,
	input  logic [tbp_pkg::MAX_IDX_W-1:0]   rd_addr,
	output tbp_pkg::tbp_bank_rd_t           rd_data,
	input  tbp_pkg::tbp_bank_wr_t           wr
);
	import tbp_pkg::*;

	localparam int DEPTH = 1 << IDX_W;

	logic [TAG_W+CTR_W-1:0] tc_mem [DEPTH];
	logic                   u0_mem [DEPTH];
	logic                   u1_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we_tc)
			tc_mem[wr.addr[IDX_W-1:0]] <= {wr.tag, wr.ctr};
		if (wr.we_u0)
			u0_mem[wr.addr[IDX_W-1:0]] <= wr.u[0];
		if (wr.we_u1)
			u1_mem[wr.addr[IDX_W-1:0]] <= wr.u[1];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			{rd_data.tag, rd_data.ctr} <= tc_mem[rd_addr[IDX_W-1:0]];
			rd_data.u                  <= {u1_mem[rd_addr[IDX_W-1:0]], u0_mem[rd_addr[IDX_W-1:0]]};
		end
	end

endmodule

// ===== src/tbp_bim.sv =====
// ----------------------------------------------------------------------------
// tbp_bim
// bimodal fallback table of two bit counters
// ----------------------------------------------------------------------------
module tbp_bim #(
	parameter int ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output logic [1:0]                 rd_data,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] wr_addr,
	input  logic [1:0]                 wr_data
);
	logic [1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== src/tbp_hist.sv =====
// ----------------------------------------------------------------------------
// tbp_hist
// global, path and folded histories, shifted once per resolved branch
// ----------------------------------------------------------------------------
module tbp_hist #(
	parameter int NUM_TABLES  = tbp_pkg::NUM_TABLES_DEF,
	parameter int MAX_HISTORY = tbp_pkg::MAX_HISTORY_DEF,
	parameter int PATH_BITS   = tbp_pkg::PATH_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tbp_pkg::tbp_hist_ctl_t      ctl,
	output logic [PATH_BITS-1:0]        path,
	output logic [tbp_pkg::TAG_W-1:0]   fidx [NUM_TABLES],
	output logic [tbp_pkg::TAG_W-1:0]   fta  [NUM_TABLES],
	output logic [tbp_pkg::TAG_W-1:0]   ftb  [NUM_TABLES]
);
	import tbp_pkg::*;

	logic [MAX_HISTORY:0]   ghist_q;
	logic [MAX_HISTORY:0]   ghist_d;
	logic [PATH_BITS-1:0]   path_q;
	logic [TAG_W-1:0]       fidx_q [NUM_TABLES];
	logic [TAG_W-1:0]       fta_q  [NUM_TABLES];
	logic [TAG_W-1:0]       ftb_q  [NUM_TABLES];

	function automatic logic [TAG_W-1:0] fold_next(input logic [TAG_W-1:0] v, input logic g0,
			input logic gh, input int unsigned w, input int unsigned s);
		logic [TAG_W:0] x;
		logic [TAG_W:0] m;
		x    = {v, g0};
		x[0] = x[0] ^ x[w];
		x[s] = x[s] ^ gh;
		m    = ((TAG_W+1)'(1) << w) - (TAG_W+1)'(1);
		return TAG_W'(x & m);
	endfunction

	assign ghist_d = {ghist_q[MAX_HISTORY-1:0], ctl.taken};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghist_q <= '0;
			path_q  <= '0;
		end else if (ctl.shift) begin
			ghist_q <= ghist_d;
			path_q  <= PATH_BITS'({path_q, ctl.taken});
		end
	end

	for (genvar i = 0; i < NUM_TABLES; i++) begin : g_fold
		localparam int H  = (HIST_LEN[i] > MAX_HISTORY) ? MAX_HISTORY : HIST_LEN[i];
		localparam int W  = TAG_WIDTH[i];
		localparam int SA = H % W;
		localparam int SB = H % (W - 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fidx_q[i] <= '0;
				fta_q[i]  <= '0;
				ftb_q[i]  <= '0;
			end else if (ctl.shift) begin
				fidx_q[i] <= fold_next(fidx_q[i], ctl.taken, ghist_d[H], W, SA);
				fta_q[i]  <= fold_next(fta_q[i], ctl.taken, ghist_d[H], W, SA);
				ftb_q[i]  <= fold_next(ftb_q[i], ctl.taken, ghist_d[H], W - 1, SB);
			end
		end

		assign fidx[i] = fidx_q[i];
		assign fta[i]  = fta_q[i];
		assign ftb[i]  = ftb_q[i];
	end

	assign path = path_q;

endmodule

// ===== src/tage_branch_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// tage_branch_predictor_unit
// tage predictor trained by one resolved branch per request
// ----------------------------------------------------------------------------
// a request (pc, taken) is taken at a clock edge with start high and busy low.
// the prediction made before training leaves on rsp with done high for exactly
// one cycle; the receiver cannot hold it off and nothing waits on it.
// cycle after the request: tables and bimodal read data come back and the
// provider, alternate, counter and useful updates are written back, so a
// branch without allocation sets done from the lookup state and, unless an
// aging sweep follows, the next request can be taken while done is high.
// an allocation steps the lfsr and takes a byte-serial remainder per free
// candidate table tried, high byte in ALLOC_HI then low byte in ALLOC_LO.
// every aging period the selected useful bit column is cleared by a sweep of
// 2048 rows, one row of every tagged table per cycle, with busy high.
// after reset a clearing sweep of max(BIMODAL_ENTRIES, 2048) rows, 16384
// by default, zeroes the tagged tables and sets the bimodal counters to
// weakly taken; busy stays high. config writes are taken at any time with
// cfg_ready high but are meant for an idle block.
// ----------------------------------------------------------------------------
module tage_branch_predictor_unit #(
	parameter int NUM_TABLES      = tbp_pkg::NUM_TABLES_DEF,
	parameter int BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF,
	parameter int MAX_HISTORY     = tbp_pkg::MAX_HISTORY_DEF,
	parameter int PATH_BITS       = tbp_pkg::PATH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tbp_pkg::tbp_req_t                 req,
	output logic                              done,
	output tbp_pkg::tbp_rsp_t                 rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tbp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tbp_pkg::*;

	localparam int BIM_W     = $clog2(BIMODAL_ENTRIES);
	localparam int CLEAR_LEN = (BIMODAL_ENTRIES > (1 << MAX_IDX_W)) ?
		BIMODAL_ENTRIES : (1 << MAX_IDX_W);
	localparam int SWP_W     = $clog2(CLEAR_LEN);
	localparam logic [SWP_W-1:0]    CLEAR_LAST = SWP_W'(CLEAR_LEN - 1);
	localparam logic [SWP_W-1:0]    AGE_LAST   = SWP_W'((1 << MAX_IDX_W) - 1);
	localparam logic [TBL_ID_W-1:0] NONE       = TBL_ID_W'(NUM_TABLES);

	tbp_state_t state_q, state_d;

	logic                 accept;
	logic [7:0]           aging_period_q;
	logic [4:0]           alloc_one_in_q;
	logic [15:0]          lfsr_q;
	logic [7:0]           aging_count_q;
	logic                 aging_phase_q;
	logic                 age_pend_q;
	logic [SWP_W-1:0]     sweep_q;
	logic                 sweep_last;
	logic [4:0]           rem_q;
	logic [NUM_TABLES-1:0] cand_q;
	logic                 done_q;
	tbp_rsp_t             rsp_q;

	logic                 taken_s1;
	logic [BIM_W-1:0]     bim_idx_s1;
	logic [MAX_IDX_W-1:0] slot_s1 [NUM_TABLES];
	logic [TAG_W-1:0]     tag_s1  [NUM_TABLES];
	logic [MAX_IDX_W-1:0] slot_d  [NUM_TABLES];
	logic [TAG_W-1:0]     tag_d   [NUM_TABLES];

	tbp_bank_rd_t         tbl_rd [NUM_TABLES];
	tbp_bank_wr_t         tbl_wr [NUM_TABLES];
	logic [1:0]           bim_rd;
	logic                 bim_we;
	logic [BIM_W-1:0]     bim_wr_addr;
	logic [1:0]           bim_wr_data;

	tbp_hist_ctl_t        hist_ctl;
	logic [PATH_BITS-1:0] path;
	logic [TAG_W-1:0]     fidx [NUM_TABLES];
	logic [TAG_W-1:0]     fta  [NUM_TABLES];
	logic [TAG_W-1:0]     ftb  [NUM_TABLES];

	// lookup stage
	logic                 hp, ha;
	logic [TBL_ID_W-1:0]  p_id, a_id;
	logic [CTR_W-1:0]     pctr, actr, pctr_new, actr_new;
	logic [1:0]           pu, pu_new;
	logic                 pu_upd, alt_upd;
	logic                 bim_pred, alt_dir, prov_pred, defer_alt, pred_dir;
	logic                 do_scan, dec_all, start_alloc;
	logic [NUM_TABLES-1:0] below, cand_d;
	logic [7:0]           aging_inc;
	logic                 age_hit;

	// allocation stage
	logic [NUM_TABLES-1:0] cur_oh;
	logic [TBL_ID_W-1:0]  cur_id;
	logic [4:0]           rem_lo;
	logic                 alloc_ok;
	logic [NUM_TABLES-1:0] cand_rest;
	logic [15:0]          lfsr_stepped;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// index and tag hashing, one bank per table
	for (genvar i = 0; i < NUM_TABLES; i++) begin : g_tbl
		localparam int IW = IDX_WIDTH[i];
		localparam int TW = TAG_WIDTH[i];
		logic [63:0] ih;
		logic [63:0] th;

		assign ih = req.pc ^ (req.pc >> IW) ^ 64'(fidx[i]) ^ 64'(path);
		assign th = req.pc ^ 64'(fta[i]) ^ (64'(ftb[i]) << 1);
		assign slot_d[i] = MAX_IDX_W'(ih[IW-1:0]);
		assign tag_d[i]  = TAG_W'(th[TW-1:0]);

		tbp_bank #(
			.IDX_W(IW)
		) u_bank (
			.clk    (clk),
			.rd_en  (accept),
			.rd_addr(slot_d[i]),
			.rd_data(tbl_rd[i]),
			.wr     (tbl_wr[i])
		);
	end

	tbp_bim #(
		.ENTRIES(BIMODAL_ENTRIES)
	) u_bim (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(req.pc[BIM_W-1:0]),
		.rd_data(bim_rd),
		.we     (bim_we),
		.wr_addr(bim_wr_addr),
		.wr_data(bim_wr_data)
	);

	assign hist_ctl.shift = (state_q == ST_LOOKUP);
	assign hist_ctl.taken = taken_s1;

	tbp_hist #(
		.NUM_TABLES (NUM_TABLES),
		.MAX_HISTORY(MAX_HISTORY),
		.PATH_BITS  (PATH_BITS)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (hist_ctl),
		.path  (path),
		.fidx  (fidx),
		.fta   (fta),
		.ftb   (ftb)
	);

	// provider and alternate selection
	always_comb begin
		hp   = 1'b0;
		ha   = 1'b0;
		p_id = NONE;
		a_id = NONE;
		pctr = '0;
		actr = '0;
		pu   = '0;
		for (int i = 0; i < NUM_TABLES; i++) begin
			if (tbl_rd[i].tag == tag_s1[i]) begin
				if (!hp) begin
					hp   = 1'b1;
					p_id = TBL_ID_W'(i);
					pctr = tbl_rd[i].ctr;
					pu   = tbl_rd[i].u;
				end else if (!ha) begin
					ha   = 1'b1;
					a_id = TBL_ID_W'(i);
					actr = tbl_rd[i].ctr;
				end
			end
		end
		bim_pred   = bim_rd[1];
		alt_dir    = ha ? actr[2] : bim_pred;
		prov_pred  = pctr[2];
		defer_alt  = hp && (pctr == 3'd3 || pctr == 3'd4) && (pu == 2'd0);
		pred_dir   = hp ? (defer_alt ? alt_dir : prov_pred) : bim_pred;
		pctr_new   = sat_ctr(pctr, taken_s1);
		actr_new   = sat_ctr(actr, taken_s1);
		pu_upd     = hp && (pred_dir != alt_dir);
		pu_new     = pu_upd ? sat_2b(pu, prov_pred == taken_s1) : pu;
		alt_upd    = hp && ha && (pu_new == 2'd0);
		do_scan    = (pred_dir != taken_s1) && (p_id != '0);
		for (int i = 0; i < NUM_TABLES; i++) begin
			below[i]  = TBL_ID_W'(i) < p_id;
			cand_d[i] = below[i] && (tbl_rd[i].u == 2'd0);
		end
		dec_all     = do_scan && (cand_d == '0);
		start_alloc = do_scan && (cand_d != '0);
		aging_inc   = aging_count_q + 8'd1;
		age_hit     = (aging_inc == aging_period_q);
	end

	// allocation candidate and remainder test
	always_comb begin
		cur_oh = '0;
		cur_id = NONE;
		for (int i = NUM_TABLES - 1; i >= 0; i--) begin
			if (cand_q[i]) begin
				cur_oh = '0;
				cur_oh[i] = 1'b1;
				cur_id = TBL_ID_W'(i);
			end
		end
		lfsr_stepped = lfsr_next(lfsr_q);
		rem_lo       = mod_byte(rem_q, lfsr_q[7:0], alloc_one_in_q);
		alloc_ok     = (rem_lo == 5'd0);
		cand_rest    = cand_q & ~cur_oh;
	end

	assign sweep_last = (state_q == ST_CLEAR) ? (sweep_q == CLEAR_LAST) : (sweep_q == AGE_LAST);

	// table write requests
	always_comb begin
		for (int i = 0; i < NUM_TABLES; i++) begin
			tbl_wr[i]      = '0;
			tbl_wr[i].addr = slot_s1[i];
			case (state_q)
				ST_CLEAR: begin
					tbl_wr[i].addr  = sweep_q[MAX_IDX_W-1:0];
					tbl_wr[i].we_tc = 1'b1;
					tbl_wr[i].we_u0 = 1'b1;
					tbl_wr[i].we_u1 = 1'b1;
				end
				ST_AGE: begin
					tbl_wr[i].addr  = sweep_q[MAX_IDX_W-1:0];
					tbl_wr[i].we_u0 = aging_phase_q;
					tbl_wr[i].we_u1 = !aging_phase_q;
				end
				ST_LOOKUP: begin
					tbl_wr[i].tag = tag_s1[i];
					if (hp && p_id == TBL_ID_W'(i)) begin
						tbl_wr[i].we_tc = 1'b1;
						tbl_wr[i].ctr   = pctr_new;
						tbl_wr[i].we_u0 = pu_upd;
						tbl_wr[i].we_u1 = pu_upd;
						tbl_wr[i].u     = pu_new;
					end
					if (alt_upd && a_id == TBL_ID_W'(i)) begin
						tbl_wr[i].we_tc = 1'b1;
						tbl_wr[i].ctr   = actr_new;
					end
					if (dec_all && below[i]) begin
						tbl_wr[i].we_u0 = 1'b1;
						tbl_wr[i].we_u1 = 1'b1;
						tbl_wr[i].u     = tbl_rd[i].u - 2'd1;
					end
				end
				ST_ALLOC_LO: begin
					tbl_wr[i].tag = tag_s1[i];
					tbl_wr[i].ctr = 3'd3 + {2'b00, taken_s1};
					tbl_wr[i].we_tc = alloc_ok && cur_oh[i];
				end
				default: begin
				end
			endcase
		end
		bim_we      = (state_q == ST_CLEAR) || (state_q == ST_LOOKUP);
		bim_wr_addr = (state_q == ST_CLEAR) ? sweep_q[BIM_W-1:0] : bim_idx_s1;
		bim_wr_data = (state_q == ST_CLEAR) ? BIM_RESET : sat_2b(bim_rd, taken_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start)
					state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (start_alloc)
					state_d = ST_ALLOC_HI;
				else if (age_hit)
					state_d = ST_AGE;
				else
					state_d = ST_IDLE;
			end
			ST_ALLOC_HI: begin
				state_d = ST_ALLOC_LO;
			end
			ST_ALLOC_LO: begin
				if (!alloc_ok && cand_rest != '0)
					state_d = ST_ALLOC_HI;
				else if (age_pend_q)
					state_d = ST_AGE;
				else
					state_d = ST_IDLE;
			end
			ST_AGE: begin
				if (sweep_last)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			taken_s1   <= req.taken;
			bim_idx_s1 <= req.pc[BIM_W-1:0];
			slot_s1    <= slot_d;
			tag_s1     <= tag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_period_q <= AGING_RESET;
			alloc_one_in_q <= ALLOC_RESET;
			lfsr_q         <= LFSR_RESET;
			aging_count_q  <= '0;
			aging_phase_q  <= 1'b0;
			age_pend_q     <= 1'b0;
			sweep_q        <= '0;
			cand_q         <= '0;
			rem_q          <= '0;
			done_q         <= 1'b0;
			rsp_q          <= '0;
		end else begin
			done_q <= (state_q == ST_LOOKUP && !start_alloc) ||
				(state_q == ST_ALLOC_LO && (alloc_ok || cand_rest == '0));
			if (cfg_valid) begin
				case (cfg_index)
					CFG_AGING_PERIOD: aging_period_q <= cfg_data[7:0];
					CFG_ALLOC_ONE_IN: alloc_one_in_q <= cfg_data[4:0];
					CFG_LFSR_SEED:    lfsr_q <= (cfg_data == '0) ? LFSR_RESET : cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == ST_CLEAR || state_q == ST_AGE)
				sweep_q <= sweep_last ? '0 : sweep_q + SWP_W'(1);
			case (state_q)
				ST_LOOKUP: begin
					rsp_q.predicted_taken <= pred_dir;
					rsp_q.provider_table  <= p_id;
					rsp_q.used_alternate  <= defer_alt;
					rsp_q.allocated_table <= NONE;
					cand_q                <= cand_d;
					age_pend_q            <= age_hit;
					aging_count_q         <= age_hit ? 8'd0 : aging_inc;
					if (age_hit)
						aging_phase_q <= !aging_phase_q;
				end
				ST_ALLOC_HI: begin
					lfsr_q <= lfsr_stepped;
					rem_q  <= mod_byte(5'd0, lfsr_stepped[15:8], alloc_one_in_q);
				end
				ST_ALLOC_LO: begin
					cand_q <= cand_rest;
					if (alloc_ok)
						rsp_q.allocated_table <= cur_id;
				end
				default: begin
				end
			endcase
		end
	end

	// a result only follows the lookup or the last allocation try
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_LOOKUP || $past(state_q) == ST_ALLOC_LO))
		else $error("result strobe outside lookup or allocation");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOKUP)
		else $error("accepted request did not enter lookup");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC_HI || state_q == ST_ALLOC_LO) |-> $onehot(cur_oh))
		else $error("allocation without a candidate table");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rsp_q.provider_table <= NONE && rsp_q.allocated_table <= NONE))
		else $error("table number out of range");

endmodule

// ===== sim/tage_branch_predictor_unit_test.sv =====
// ----------------------------------------------------------------------------
// tage_branch_predictor_unit_test
// self-checking bench: a cycle-free model of the predictor trains alongside
// the block and every done strobe is compared field by field, in order, with
// the prediction expected for the oldest outstanding branch request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tage_branch_predictor_unit_test;
	import tbp_pkg::*;

	localparam int NT          = NUM_TABLES_DEF;
	localparam int ALL_ENTRIES = 15360;
	localparam int BIM_N       = BIMODAL_ENTRIES_DEF;
	localparam int HMAX        = MAX_HISTORY_DEF;
	localparam int DRAIN_WAIT  = 2200;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	class tbp_scoreboard;
		bit [2:0]  ctr [ALL_ENTRIES];
		bit [1:0]  useful [ALL_ENTRIES];
		bit [14:0] tagv [ALL_ENTRIES];
		bit [1:0]  bim [BIM_N];
		bit        ghist [HMAX + 1];
		bit [15:0] path;
		bit [31:0] fidx [NT];
		bit [31:0] fta [NT];
		bit [31:0] ftb [NT];
		int        base [NT];
		bit [7:0]  age_cnt;
		bit        age_ph;
		bit [7:0]  period;
		bit [4:0]  div_reg;
		bit [15:0] lfsr;
		tbp_rsp_t  pending_q [$];
		int        errors;

		function new();
			int acc;
			acc = 0;
			for (int i = 0; i < NT; i++) begin
				base[i] = acc;
				acc += 1 << IDX_WIDTH[i];
			end
			foreach (ctr[e]) begin
				ctr[e] = 0;
				useful[e] = 0;
				tagv[e] = 0;
			end
			foreach (bim[e])
				bim[e] = BIM_RESET;
			foreach (ghist[e])
				ghist[e] = 0;
			foreach (fidx[i]) begin
				fidx[i] = 0;
				fta[i] = 0;
				ftb[i] = 0;
			end
			path = 0;
			age_cnt = 0;
			age_ph = 0;
			period = AGING_RESET;
			div_reg = ALLOC_RESET;
			lfsr = LFSR_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_AGING_PERIOD: period = data[7:0];
				CFG_ALLOC_ONE_IN: div_reg = data[4:0];
				CFG_LFSR_SEED: begin
					lfsr = (data == 0) ? 16'd1 : data;
				end
				default: ;
			endcase
		endfunction

		function bit [31:0] fold(bit [31:0] v, int h, int w);
			v = (v << 1) | ghist[0];
			v ^= (v >> w) & 1;
			v ^= 32'(ghist[h]) << (h % w);
			return v & ((32'd1 << w) - 1);
		endfunction

		function bit [2:0] sat3(bit [2:0] v, bit up);
			if (up && v != 7) return v + 1;
			if (!up && v != 0) return v - 1;
			return v;
		endfunction

		function bit [1:0] sat2(bit [1:0] v, bit up);
			if (up && v != 3) return v + 1;
			if (!up && v != 0) return v - 1;
			return v;
		endfunction

		function tbp_rsp_t train(tbp_req_t r);
			int slot [NT];
			bit [14:0] tg [NT];
			int prov, alt, alloc, w, bi, k, s, hl, dv;
			logic [63:0] h;
			bit tk, bim_pred, prov_pred, defer_alt, fin, alt_dir;
			tbp_rsp_t o;
			prov = NT;
			alt = NT;
			alloc = NT;
			tk = r.taken;
			for (int i = 0; i < NT; i++) begin
				w = IDX_WIDTH[i];
				h = r.pc ^ (r.pc >> w) ^ 64'(fidx[i]) ^ 64'(path);
				slot[i] = base[i] + int'(h & ((64'd1 << w) - 1));
				h = r.pc ^ 64'(fta[i]) ^ (64'(ftb[i]) << 1);
				tg[i] = 15'(h & ((64'd1 << TAG_WIDTH[i]) - 1));
			end
			for (int i = 0; i < NT; i++) begin
				if (tagv[slot[i]] == tg[i]) begin
					if (prov == NT) prov = i;
					else begin
						alt = i;
						break;
					end
				end
			end
			bi = int'(r.pc % BIM_N);
			bim_pred = bim[bi] > 1;
			prov_pred = 0;
			defer_alt = 0;
			alt_dir = (alt < NT) ? (ctr[slot[alt]] >= 4) : bim_pred;
			if (prov < NT) begin
				prov_pred = ctr[slot[prov]] >= 4;
				defer_alt = (ctr[slot[prov]] == 3 || ctr[slot[prov]] == 4)
					&& useful[slot[prov]] == 0;
				fin = defer_alt ? alt_dir : prov_pred;
				s = slot[prov];
				ctr[s] = sat3(ctr[s], tk);
				if (fin != alt_dir)
					useful[s] = sat2(useful[s], prov_pred == tk);
				if (alt < NT && useful[s] == 0)
					ctr[slot[alt]] = sat3(ctr[slot[alt]], tk);
			end else
				fin = bim_pred;
			bim[bi] = sat2(bim[bi], tk);

			if (fin != tk && prov != 0) begin
				k = NT;
				dv = (div_reg == 0) ? 1 : div_reg;
				for (int i = 0; i < prov; i++)
					if (useful[slot[i]] == 0) begin
						k = i;
						break;
					end
				if (k == NT) begin
					for (int i = 0; i < prov; i++)
						useful[slot[i]] = useful[slot[i]] - 1;
				end else begin
					for (int i = k; i < prov; i++) begin
						if (useful[slot[i]] != 0) continue;
						lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
						if (lfsr % dv == 0) begin
							ctr[slot[i]] = tk ? 3'd4 : 3'd3;
							tagv[slot[i]] = tg[i];
							alloc = i;
							break;
						end
					end
				end
			end

			for (int j = HMAX; j > 0; j--)
				ghist[j] = ghist[j - 1];
			ghist[0] = tk;
			path = {path[14:0], tk};
			for (int i = 0; i < NT; i++) begin
				hl = (HIST_LEN[i] > HMAX) ? HMAX : HIST_LEN[i];
				w = TAG_WIDTH[i];
				fidx[i] = fold(fidx[i], hl, w);
				fta[i] = fold(fta[i], hl, w);
				ftb[i] = fold(ftb[i], hl, w - 1);
			end
			age_cnt = age_cnt + 8'd1;
			if (age_cnt == period) begin
				age_cnt = 0;
				age_ph ^= 1;
				foreach (useful[e])
					useful[e] &= {1'b0, age_ph} + 2'd1;
			end

			o.predicted_taken = fin;
			o.provider_table = TBL_ID_W'(prov);
			o.used_alternate = defer_alt;
			o.allocated_table = TBL_ID_W'(alloc);
			return o;
		endfunction

		function void note_request(tbp_req_t r);
			pending_q.push_back(train(r));
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(tbp_rsp_t got);
			tbp_rsp_t exp_r;
			if (pending_q.size() == 0) begin
				report("result with no request outstanding");
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.predicted_taken !== exp_r.predicted_taken)
				report($sformatf("predicted_taken %0b want %0b",
					got.predicted_taken, exp_r.predicted_taken));
			if (got.provider_table !== exp_r.provider_table)
				report($sformatf("provider_table %0d want %0d",
					got.provider_table, exp_r.provider_table));
			if (got.used_alternate !== exp_r.used_alternate)
				report($sformatf("used_alternate %0b want %0b",
					got.used_alternate, exp_r.used_alternate));
			if (got.allocated_table !== exp_r.allocated_table)
				report($sformatf("allocated_table %0d want %0d",
					got.allocated_table, exp_r.allocated_table));
		endtask
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  start = 0;
	logic                  busy;
	tbp_req_t              req = '0;
	logic                  done;
	tbp_rsp_t              rsp;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tbp_scoreboard sb = new();
	int            burst_left = 0;
	logic [63:0]   pc_pool [24];
	int            branch_count = 0;

	tage_branch_predictor_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(rsp);
	end

	task send_branch(logic [63:0] pc, logic tk);
		int gap;
		start <= 1'b1;
		req <= '{pc: pc, taken: tk};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request('{pc: pc, taken: tk});
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// wait for every prediction, any aging sweep, then idle
	task wait_idle();
		start <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly recurring branches with learnable outcomes, some noise
	task random_branch();
		int k;
		logic tk;
		branch_count++;
		if ($urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, 23);
			case (k % 4)
				0: tk = 1'b1;
				1: tk = (branch_count % 4) != 0;
				2: tk = sb.ghist[0] ^ sb.ghist[2];
				default: tk = $urandom_range(0, 1);
			endcase
			send_branch(pc_pool[k], tk);
		end else
			send_branch({$urandom(), $urandom()}, $urandom_range(0, 1));
	endtask

	task run_phase(logic [7:0] aging, logic [4:0] alloc, logic [15:0] seed, int n);
		wait_idle();
		write_reg(CFG_AGING_PERIOD, {8'd0, aging});
		write_reg(CFG_ALLOC_ONE_IN, {11'd0, alloc});
		write_reg(CFG_LFSR_SEED, seed);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_idle();
			random_branch();
		end
	endtask

	initial begin
		foreach (pc_pool[i])
			pc_pool[i] = {$urandom(), $urandom()};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// directed: address extremes, then one branch trained to allocate
		send_branch(64'd0, 1'b0);
		send_branch(64'd0, 1'b1);
		send_branch('1, 1'b0);
		send_branch('1, 1'b1);
		send_branch(64'h8000_0000_0000_0000, 1'b0);
		send_branch(64'h0000_0000_0000_3fff, 1'b1);
		for (int i = 0; i < 14; i++)
			send_branch(64'h1234_5678_9abc_def0, i[0]);
		for (int i = 0; i < 4; i++)
			send_branch(64'h0000_0000_0000_0040, 1'b0);

		run_phase(8'd255, 5'd1, 16'hffff, 300);
		run_phase(8'd1, 5'd16, 16'd0, 30);
		run_phase(8'd0, 5'd0, 16'hace1, 400);
		run_phase(8'd7, 5'd31, 16'($urandom_range(1, 65535)), 400);
		wait_idle();
		write_reg(CFG_UNMAPPED, 16'hffff);
		run_phase(8'd20, 5'd12, 16'd1, 650);

		start <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.pending_q.size() != 0)
			sb.report("predictions still outstanding at end of run");
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/tbp_pkg.sv
src/tbp_bank.sv
src/tbp_bim.sv
src/tbp_hist.sv
src/tage_branch_predictor_unit.sv
sim/tage_branch_predictor_unit_test.sv
